>>> hdl/srtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int ID_W    = 8;
   localparam int TIME_W  = 16;
   localparam int BURST_W = 8;
   localparam int ORDER_W = 16;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    task_id;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
      logic               started;
      logic [ORDER_W-1:0] entry_order;
   } slot_type;

   typedef struct packed {
      logic               status;
      logic               idle;
      logic [ID_W-1:0]    running_id;
      logic               first_run;
      logic [TIME_W-1:0]  response_time;
      logic               finished;
      logic [TIME_W-1:0]  completion_time;
      logic [TIME_W-1:0]  turnaround_time;
      logic [TIME_W-1:0]  waiting_time;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
   } pick_ctl_type;

endpackage

>>> hdl/srtf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module srtf_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/srtf_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pick
// Shared compare unit that keeps the best task seen during a table scan.
// ----------------------------------------------------------------------------
module srtf_pick #(
   parameter int IDX_W = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srtf_pkg::pick_ctl_type ctl,
   input  srtf_pkg::slot_type    cand,
   input  logic [IDX_W-1:0]      cand_slot,
   output logic                  found,
   output srtf_pkg::slot_type    best,
   output logic [IDX_W-1:0]      best_slot
);

   import srtf_pkg::*;

   logic       found_ff;
   logic       found_in;
   slot_type   best_ff;
   logic [IDX_W-1:0] best_slot_ff;
   logic       better;

   always_comb begin
      better = !found_ff
            || (cand.remaining < best_ff.remaining)
            || ((cand.remaining == best_ff.remaining)
                && (cand.entry_order < best_ff.entry_order));
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.load && better) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctl.clear && ctl.load && better) begin
         best_ff      <= cand;
         best_slot_ff <= cand_slot;
      end
   end

   assign found     = found_ff;
   assign best      = best_ff;
   assign best_slot = best_slot_ff;

endmodule

>>> hdl/srtf_preemptive_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// Preemptive shortest-remaining-time-first scheduler over a task table.
// ----------------------------------------------------------------------------
// A tick request scans the table one slot per cycle through the shared
// compare unit and the registered memory read, then passes an update state
// and an output state that waits while the previous response is unaccepted.
// An arrival runs a free-slot search, one slot per cycle, then goes to the
// output state. The next request is accepted once the block is idle again.
// Reset empties the table, clears the entry counter and sets time to one.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_arrival_stamp,
   input  logic [7:0]  req_burst,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic        rsp_idle,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_first_run,
   output logic [15:0] rsp_response_time,
   output logic        rsp_finished,
   output logic [15:0] rsp_completion_time,
   output logic [15:0] rsp_turnaround_time,
   output logic [15:0] rsp_waiting_time
);

   import srtf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_SEND  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ORDER_W-1:0]     entry_ff, entry_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                res_ff, res_in;
   logic                   res_load;
   logic [ID_W-1:0]        id_ff;
   logic [TIME_W-1:0]      arr_ff;
   logic [BURST_W-1:0]     burst_ff;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   slot_type               wr_data;
   logic [IDX_W-1:0]       rd_addr;
   slot_type               rd_data;

   pick_ctl_type           pick_ctl;
   logic                   best_found;
   slot_type               best;
   logic [IDX_W-1:0]       best_slot;

   logic [IDX_W-1:0]       cur_idx;
   logic [CNT_W-1:0]       cnt_m1;
   logic [IDX_W-1:0]       cmp_idx;
   logic                   accept;
   logic                   send;
   logic [TIME_W-1:0]      done_time;
   logic [TIME_W-1:0]      tat_time;
   logic                   fin;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign send    = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_ready);
   assign cur_idx = cnt_ff[IDX_W-1:0];
   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign cmp_idx = cnt_m1[IDX_W-1:0];
   assign rd_addr = cur_idx;

   assign done_time = time_ff + TIME_W'(1);
   assign tat_time  = done_time - best.arrival;
   assign fin       = (best.remaining <= BURST_W'(1));

   srtf_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srtf_pick #(
      .IDX_W (IDX_W)
   ) u_pick (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pick_ctl),
      .cand      (rd_data),
      .cand_slot (cmp_idx),
      .found     (best_found),
      .best      (best),
      .best_slot (best_slot)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      entry_in     = entry_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff;
      res_in       = '0;
      res_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_idx;
      wr_data      = '0;
      pick_ctl     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               pick_ctl.clear = 1'b1;
               state_in = (req_cmd == CMD_TICK) ? S_SCAN : S_FIND;
            end
         end
         S_FIND: begin
            if (!valid_ff[cur_idx]) begin
               wr_en               = 1'b1;
               wr_data.task_id     = id_ff;
               wr_data.arrival     = arr_ff;
               wr_data.burst       = burst_ff;
               wr_data.remaining   = burst_ff;
               wr_data.started     = 1'b0;
               wr_data.entry_order = entry_ff;
               valid_in[cur_idx]   = 1'b1;
               entry_in            = entry_ff + ORDER_W'(1);
               res_in.status       = STATUS_OK;
               res_load            = 1'b1;
               state_in            = S_SEND;
            end else if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               res_in.status = STATUS_FULL;
               res_load      = 1'b1;
               state_in      = S_SEND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_SCAN: begin
            pick_ctl.load = (cnt_ff != '0) && valid_ff[cmp_idx];
            if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               state_in = S_APPLY;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_APPLY: begin
            res_load = 1'b1;
            time_in  = time_ff + TIME_W'(1);
            if (!best_found) begin
               res_in.idle = 1'b1;
            end else begin
               res_in.running_id = best.task_id;
               if (!best.started) begin
                  res_in.first_run     = 1'b1;
                  res_in.response_time = time_ff - best.arrival;
               end
               wr_addr = best_slot;
               if (fin) begin
                  valid_in[best_slot]    = 1'b0;
                  res_in.finished        = 1'b1;
                  res_in.completion_time = done_time;
                  res_in.turnaround_time = tat_time;
                  res_in.waiting_time    = tat_time - TIME_W'(best.burst);
               end else begin
                  wr_en             = 1'b1;
                  wr_data           = best;
                  wr_data.started   = 1'b1;
                  wr_data.remaining = best.remaining - BURST_W'(1);
               end
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            if (send) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         entry_ff     <= '0;
         time_ff      <= TIME_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         entry_ff     <= entry_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff    <= req_task_id;
         arr_ff   <= req_arrival_stamp;
         burst_ff <= req_burst;
      end
      if (res_load) begin
         res_ff <= res_in;
      end
      if (send) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_idle            = rsp_ff.idle;
   assign rsp_running_id      = rsp_ff.running_id;
   assign rsp_first_run       = rsp_ff.first_run;
   assign rsp_response_time   = rsp_ff.response_time;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_completion_time = rsp_ff.completion_time;
   assign rsp_turnaround_time = rsp_ff.turnaround_time;
   assign rsp_waiting_time    = rsp_ff.waiting_time;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the SRTF preemptive scheduler.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver. Every accepted request is run
// through a local scheduler model, and the monitor compares each response,
// field by field, with the oldest predicted outcome. A directed opening
// covers the field extremes and the corner cases. Random episodes of
// arrivals and ticks follow, with random gaps and stalls on both sides and
// a quiet ending.
// ----------------------------------------------------------------------------
module testbench;
   import srtf_pkg::*;

   localparam int TABLE_DEPTH  = 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_FROM   = 650;
   localparam int TIMEOUT_NS   = 1_000_000;

   typedef struct packed {
      logic               cmd;
      logic [ID_W-1:0]    task_id;
      logic [TIME_W-1:0]  stamp;
      logic [BURST_W-1:0] burst;
      logic               quiet;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_TICK;
   logic [7:0]  req_task_id = '0;
   logic [15:0] req_arrival_stamp = '0;
   logic [7:0]  req_burst = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic        rsp_idle;
   logic [7:0]  rsp_running_id;
   logic        rsp_first_run;
   logic [15:0] rsp_response_time;
   logic        rsp_finished;
   logic [15:0] rsp_completion_time;
   logic [15:0] rsp_turnaround_time;
   logic [15:0] rsp_waiting_time;

   request_type request_q[$];
   rsp_type     outcome_q[$];
   request_type cur_req = '0;

   slot_type          task_tab[TABLE_DEPTH];
   logic              task_used[TABLE_DEPTH] = '{default: 1'b0};
   logic [ORDER_W-1:0] next_order = '0;
   logic [TIME_W-1:0] now_time = 16'd1;

   logic [TIME_W-1:0] gen_time = 16'd1;
   logic              quiet_mode = 1'b0;
   logic              calm = 1'b0;
   int                gen_count = 0;
   int                gap_left = 0;
   int                stall_left = 0;
   int                mismatches = 0;
   int                rsp_count = 0;
   int                n_arrivals = 0;
   int                n_full = 0;
   int                n_ticks = 0;
   int                n_idle = 0;
   int                n_finished = 0;

   srtf_preemptive_scheduler #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_task_id         (req_task_id),
      .req_arrival_stamp   (req_arrival_stamp),
      .req_burst           (req_burst),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_idle            (rsp_idle),
      .rsp_running_id      (rsp_running_id),
      .rsp_first_run       (rsp_first_run),
      .rsp_response_time   (rsp_response_time),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time)
   );

   always #1 clock = ~clock;

   function automatic rsp_type srtf_outcome(input request_type r);
      rsp_type           o;
      int                i;
      int                free_slot;
      int                pick;
      logic [TIME_W-1:0] done_at;
      logic [TIME_W-1:0] tat;
      o = '0;
      if (r.cmd == CMD_ARRIVAL) begin
         n_arrivals++;
         free_slot = -1;
         for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!task_used[i]) free_slot = i;
         end
         if (free_slot < 0) begin
            o.status = STATUS_FULL;
            n_full++;
         end else begin
            task_used[free_slot] = 1'b1;
            task_tab[free_slot].task_id     = r.task_id;
            task_tab[free_slot].arrival     = r.stamp;
            task_tab[free_slot].burst       = r.burst;
            task_tab[free_slot].remaining   = r.burst;
            task_tab[free_slot].started     = 1'b0;
            task_tab[free_slot].entry_order = next_order;
            next_order++;
         end
      end else begin
         n_ticks++;
         pick = -1;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            if (task_used[i]) begin
               if (pick < 0) pick = i;
               else if (task_tab[i].remaining < task_tab[pick].remaining ||
                        (task_tab[i].remaining == task_tab[pick].remaining &&
                         task_tab[i].entry_order < task_tab[pick].entry_order))
                  pick = i;
            end
         end
         if (pick < 0) begin
            o.idle = 1'b1;
            n_idle++;
         end else begin
            o.running_id = task_tab[pick].task_id;
            if (!task_tab[pick].started) begin
               task_tab[pick].started = 1'b1;
               o.first_run = 1'b1;
               o.response_time = now_time - task_tab[pick].arrival;
            end
            if (task_tab[pick].remaining <= 1) begin
               done_at = now_time + 16'd1;
               tat = done_at - task_tab[pick].arrival;
               task_tab[pick].remaining = '0;
               task_used[pick] = 1'b0;
               o.finished = 1'b1;
               o.completion_time = done_at;
               o.turnaround_time = tat;
               o.waiting_time = tat - TIME_W'(task_tab[pick].burst);
               n_finished++;
            end else begin
               task_tab[pick].remaining--;
            end
         end
         now_time++;
      end
      return o;
   endfunction

   task automatic push_arrival(input logic [7:0] id, input logic [15:0] stamp,
                               input logic [7:0] burst);
      request_type r;
      r = '{cmd: CMD_ARRIVAL, task_id: id, stamp: stamp, burst: burst, quiet: quiet_mode};
      request_q = {request_q, r};
      gen_count++;
   endtask

   task automatic push_tick();
      request_type r;
      r = '{cmd: CMD_TICK, task_id: 8'($urandom), stamp: 16'($urandom),
            burst: 8'($urandom), quiet: quiet_mode};
      request_q = {request_q, r};
      gen_time++;
      gen_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in response %0d, %s: expected %0h, got %0h",
                     rsp_count, name, want, got);
      end
   endtask

   // Driver.
   always @(posedge clock) begin
      logic hold;
      hold = req_valid && !req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q = {outcome_q, srtf_outcome(cur_req)};
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
               if (!request_q[0].quiet && $urandom_range(0, 4) == 0) begin
                  gap_left = $urandom_range(0, 12);
                  req_valid <= 1'b0;
               end else begin
                  cur_req = request_q.pop_front();
                  calm = cur_req.quiet;
                  req_cmd <= cur_req.cmd;
                  req_task_id <= cur_req.task_id;
                  req_arrival_stamp <= cur_req.stamp;
                  req_burst <= cur_req.burst;
                  req_valid <= 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Response %0d arrived with no request outstanding", rsp_count);
            end else begin
               want = outcome_q.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("idle", 16'(want.idle), 16'(rsp_idle));
               check_field("running_id", 16'(want.running_id), 16'(rsp_running_id));
               check_field("first_run", 16'(want.first_run), 16'(rsp_first_run));
               check_field("response_time", want.response_time, rsp_response_time);
               check_field("finished", 16'(want.finished), 16'(rsp_finished));
               check_field("completion_time", want.completion_time, rsp_completion_time);
               check_field("turnaround_time", want.turnaround_time, rsp_turnaround_time);
               check_field("waiting_time", want.waiting_time, rsp_waiting_time);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d requests queued and %0d responses outstanding",
               request_q.size(), outcome_q.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int i;
      int ticks_left;
      int k;
      int m;
      int r;
      logic [15:0] stamp;
      logic [7:0]  burst;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: idle tick, field extremes, zero burst, duplicate
      // ids, wrapped and late stamps, ties and a full table.
      push_tick();
      push_arrival(8'h00, 16'h0000, 8'hFF);
      push_arrival(8'hFF, 16'hFFFF, 8'h01);
      push_arrival(8'hA5, 16'h0001, 8'h00);
      push_arrival(8'hA5, 16'h0002, 8'h01);
      repeat (3) push_tick();
      for (i = 0; i < TABLE_DEPTH; i++) begin
         push_arrival(8'h10 + 8'(i), (i == 3) ? 16'h8000 : gen_time, 8'h03);
      end
      repeat (4) push_tick();
      wait_drained();

      ticks_left = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (task_used[i])
            ticks_left += (task_tab[i].remaining == 0) ? 1 : int'(task_tab[i].remaining);
      end
      repeat (ticks_left) push_tick();
      wait_drained();

      quiet_mode = 1'b0;
      gen_time = now_time;
      gen_count = 0;
      while (gen_count < RANDOM_ITEMS) begin
         k = $urandom_range(1, 10);
         m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(4, 40);
         for (i = 0; i < k; i++) begin
            quiet_mode = (gen_count >= QUIET_FROM);
            r = $urandom_range(0, 99);
            if (r < 5) burst = 8'h00;
            else if (r == 5) burst = 8'($urandom);
            else burst = 8'($urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0) stamp = 16'($urandom);
            else stamp = gen_time - 16'($urandom_range(0, 3));
            push_arrival(8'($urandom), stamp, burst);
         end
         for (i = 0; i < m; i++) begin
            quiet_mode = (gen_count >= QUIET_FROM);
            push_tick();
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      $display("Checked %0d responses: %0d arrivals, %0d of them refused on a full table.",
               rsp_count, n_arrivals, n_full);
      $display("Ticks: %0d, %0d idle, %0d task completions.",
               n_ticks, n_idle, n_finished);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> srtf_preemptive_scheduler.f
hdl/srtf_pkg.sv
hdl/srtf_ram.sv
hdl/srtf_pick.sv
hdl/srtf_preemptive_scheduler.sv
tb/sv/testbench.sv
